// ----- hw/rtl/telm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// telm_pkg
// Shared widths, register indexes, reset values and constants for the
// torque moving-average limit monitor.
// ---------------------------------------------------------------------------
package telm_pkg;

   localparam int CHANNELS_DEFAULT = 4;

   localparam int CHAN_W   = 2;
   localparam int TORQUE_W = 16;
   localparam int ALPHA_W  = 17;
   localparam int OFFSET_W = 16;
   localparam int LIMIT_W  = 15;
   localparam int FRAC_W   = 8;
   localparam int AVG_W    = TORQUE_W + FRAC_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = ALPHA_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA  = 2'd0,
      CSR_OFFSET = 2'd1,
      CSR_LIMIT  = 2'd2
   } csr_idx_type;

   localparam logic [ALPHA_W-1:0]         ALPHA_RESET  = 17'd6554;
   localparam logic [ALPHA_W-1:0]         ALPHA_ONE    = 17'd65536;
   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 16'sd0;
   localparam logic [LIMIT_W-1:0]         LIMIT_RESET  = 15'd10000;
   localparam logic signed [TORQUE_W-1:0] ERROR_FLOOR  = -16'sd10000;

endpackage : telm_pkg
`default_nettype wire

// ----- hw/rtl/torque_ewma_limit_monitor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// torque_ewma_limit_monitor
// Per-channel exponential moving average of torque samples, offset, saturate
// and compare against a magnitude limit.
// ---------------------------------------------------------------------------
// One request per clock is sustained while the response side is not
// stalled; each request yields exactly one response, which is registered.
// A request is captured in an input register, then a single pass
// (one 25x18 multiply, an add, offset, abs compare) produces the response
// register and updates the channel average at the same edge, so requests on
// the same channel may follow each other with no gap. Configuration writes
// take effect on the next request and must be made while the block is idle.
module torque_ewma_limit_monitor
   #(
      parameter int CHANNELS = telm_pkg::CHANNELS_DEFAULT
   )
   (
      input  wire logic                                   clock,
      input  wire logic                                   reset,

      input  wire logic                                   req_valid,
      output logic                                        req_ready,
      input  wire logic [telm_pkg::CHAN_W-1:0]            req_channel,
      input  wire logic                                   req_motor_enabled,
      input  wire logic                                   req_steps_active,
      input  wire logic signed [telm_pkg::TORQUE_W-1:0]   req_raw_torque,

      output logic                                        rsp_valid,
      input  wire logic                                   rsp_ready,
      output logic                                        rsp_over_limit,
      output logic signed [telm_pkg::TORQUE_W-1:0]        rsp_reported_torque,
      output logic                                        rsp_sample_used,

      input  wire logic                                   csr_we,
      input  wire logic [telm_pkg::CSR_IDX_W-1:0]         csr_index,
      input  wire logic [telm_pkg::CSR_DATA_W-1:0]        csr_wdata
   );

   import telm_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration
   logic [ALPHA_W-1:0]         alpha_ff;
   logic signed [OFFSET_W-1:0] offset_ff;
   logic [LIMIT_W-1:0]         limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_RESET;
         offset_ff <= OFFSET_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ALPHA:  alpha_ff  <= csr_wdata;
            CSR_OFFSET: offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_LIMIT:  limit_ff  <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic                       s1_valid_ff;
   logic [CHAN_W-1:0]          s1_channel_ff;
   logic                       s1_enabled_ff;
   logic                       s1_active_ff;
   logic signed [TORQUE_W-1:0] s1_raw_ff;
   logic                       s1_advance;
   logic                       out_free;

   assign out_free   = !rsp_valid || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_channel_ff <= req_channel;
         s1_enabled_ff <= req_motor_enabled;
         s1_active_ff  <= req_steps_active;
         s1_raw_ff     <= req_raw_torque;
      end
   end

   // channel state
   logic [AVG_W-1:0] avg_store_ff [CHANNELS];
   logic [CHANNELS-1:0] unseeded_ff;

   // single-pass datapath
   logic [IDX_W-1:0]               idx;
   logic                           chan_ok;
   logic                           use_sample;
   logic [ALPHA_W-1:0]             alpha_eff;
   logic signed [AVG_W-1:0]        avg_old;
   logic signed [AVG_W-1:0]        seed_val;
   logic signed [AVG_W:0]          diff;
   logic signed [AVG_W+ALPHA_W+1:0] prod;
   logic signed [AVG_W:0]          upd_sum;
   logic signed [AVG_W-1:0]        avg_new;
   logic signed [AVG_W:0]          full;
   logic [AVG_W:0]                 mag;
   logic                           over_in;
   logic signed [TORQUE_W:0]       rep_wide;
   logic signed [TORQUE_W-1:0]     rep_sat;

   always_comb begin
      idx        = IDX_W'(32'(s1_channel_ff));
      chan_ok    = 32'(s1_channel_ff) < 32'(CHANNELS);
      use_sample = chan_ok && s1_enabled_ff && s1_active_ff &&
                   !(s1_raw_ff < ERROR_FLOOR);
      alpha_eff  = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      avg_old    = avg_store_ff[idx];
      seed_val   = {s1_raw_ff, {FRAC_W{1'b0}}};
      diff       = {seed_val[AVG_W-1], seed_val} - {avg_old[AVG_W-1], avg_old};
      // avg + floor(alpha * (x - avg) / 2^16)
      prod       = diff * $signed({1'b0, alpha_eff});
      upd_sum    = {avg_old[AVG_W-1], avg_old} + prod[AVG_W+16:16];
      avg_new    = unseeded_ff[idx] ? seed_val : upd_sum[AVG_W-1:0];
      full       = {avg_new[AVG_W-1], avg_new} +
                   {offset_ff[OFFSET_W-1], offset_ff, {FRAC_W{1'b0}}};
      mag        = full[AVG_W] ? (AVG_W+1)'(-full) : full;
      over_in    = mag > (AVG_W+1)'({limit_ff, {FRAC_W{1'b0}}});
      rep_wide   = {avg_new[AVG_W-1], avg_new[AVG_W-1:FRAC_W]} +
                   {offset_ff[OFFSET_W-1], offset_ff};
      if (rep_wide[TORQUE_W] != rep_wide[TORQUE_W-1]) begin
         rep_sat = rep_wide[TORQUE_W] ? {1'b1, {(TORQUE_W-1){1'b0}}}
                                      : {1'b0, {(TORQUE_W-1){1'b1}}};
      end else begin
         rep_sat = rep_wide[TORQUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unseeded_ff <= '1;
      end else if (s1_advance && use_sample) begin
         unseeded_ff[idx] <= 1'b0;
      end
      if (s1_advance && use_sample) begin
         avg_store_ff[idx] <= avg_new;
      end
   end

   // response register
   logic                       rsp_valid_ff;
   logic                       rsp_over_ff;
   logic signed [TORQUE_W-1:0] rsp_torque_ff;
   logic                       rsp_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_advance) begin
         rsp_over_ff   <= use_sample && over_in;
         rsp_torque_ff <= use_sample ? rep_sat : '0;
         rsp_used_ff   <= use_sample;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_over_limit      = rsp_over_ff;
   assign rsp_reported_torque = rsp_torque_ff;
   assign rsp_sample_used     = rsp_used_ff;

   // assertions
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sample_used |-> !rsp_over_limit && rsp_reported_torque == '0)
      else $error("unused request produced nonzero response");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid)
      else $error("input stage advanced without a response");

   a_seeded: assert property (@(posedge clock) disable iff (reset)
      s1_advance && use_sample |=> !unseeded_ff[$past(idx)])
      else $error("used sample left channel unseeded");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff)
      else $error("stalled request dropped from input stage");

endmodule : torque_ewma_limit_monitor
`default_nettype wire

// ----- test/torque_ewma_limit_monitor_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// torque_ewma_limit_monitor_tb
// Self-checking bench for the torque moving-average limit monitor. Directed
// and random torque requests are sent with random gaps on both handshakes.
// A per-channel moving-average predictor in the bench computes each
// response, and the responses are checked in order. CSR settings, extremes
// among them, change between phases while the block is idle.
// ---------------------------------------------------------------------------
module torque_ewma_limit_monitor_tb;
   import telm_pkg::*;

   localparam int CHANNELS       = CHANNELS_DEFAULT;
   localparam int PHASES         = 8;
   localparam int USED_PER_PHASE = 160;
   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLD_AT        = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int STALL_LIMIT    = 5000;

   typedef struct packed {
      logic [CHAN_W-1:0]          channel;
      logic                       motor_enabled;
      logic                       steps_active;
      logic signed [TORQUE_W-1:0] raw_torque;
   } torque_sample_type;

   typedef struct packed {
      logic                       over_limit;
      logic signed [TORQUE_W-1:0] reported_torque;
      logic                       sample_used;
   } torque_report_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [CHAN_W-1:0]          req_channel;
   logic                       req_motor_enabled;
   logic                       req_steps_active;
   logic signed [TORQUE_W-1:0] req_raw_torque;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_over_limit;
   logic signed [TORQUE_W-1:0] rsp_reported_torque;
   logic                       rsp_sample_used;
   logic                       csr_we;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   // bench copy of the block's configuration and per-channel state
   logic [ALPHA_W-1:0]         alpha_cfg;
   logic signed [OFFSET_W-1:0] offset_cfg;
   logic [LIMIT_W-1:0]         limit_cfg;
   logic signed [AVG_W-1:0]    avg_store [CHANNELS];
   logic                       unseeded [CHANNELS];

   torque_sample_type sample_q [$];
   torque_report_type report_q [$];
   torque_sample_type tx_sample;

   int tx_gap;
   int tx_calm;
   int rx_stall;
   int rx_calm;
   int rsp_hits;
   bit hold_done;
   int fail_count;
   int idle_cycles;

   torque_ewma_limit_monitor #(.CHANNELS(CHANNELS)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_channel         (req_channel),
      .req_motor_enabled   (req_motor_enabled),
      .req_steps_active    (req_steps_active),
      .req_raw_torque      (req_raw_torque),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_over_limit      (rsp_over_limit),
      .rsp_reported_torque (rsp_reported_torque),
      .rsp_sample_used     (rsp_sample_used),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic torque_report_type predict_report(torque_sample_type s);
      torque_report_type rpt;
      longint weight, raw_fx, avg, full, mag, rep;
      int ch;
      rpt = '0;
      ch = s.channel;
      if (!s.motor_enabled || !s.steps_active || ch >= CHANNELS)
         return rpt;
      if ($signed(s.raw_torque) < ERROR_FLOOR)
         return rpt;
      weight = (alpha_cfg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_cfg);
      raw_fx = longint'($signed(s.raw_torque)) * 256;
      if (unseeded[ch]) begin
         avg = raw_fx;
         unseeded[ch] = 1'b0;
      end else begin
         avg = (weight * raw_fx +
                (longint'(ALPHA_ONE) - weight) * longint'(avg_store[ch])) >>> 16;
      end
      avg_store[ch] = avg[AVG_W-1:0];
      full = avg + longint'(offset_cfg) * 256;
      mag = (full < 0) ? -full : full;
      rep = (avg >>> FRAC_W) + longint'(offset_cfg);
      if (rep > 32767)
         rep = 32767;
      else if (rep < -32768)
         rep = -32768;
      rpt.over_limit = (mag > longint'(limit_cfg) * 256);
      rpt.reported_torque = rep[TORQUE_W-1:0];
      rpt.sample_used = 1'b1;
      return rpt;
   endfunction

   task automatic push_sample(int ch, bit en, bit mv, int raw);
      torque_sample_type s;
      s.channel = ch[CHAN_W-1:0];
      s.motor_enabled = en;
      s.steps_active = mv;
      s.raw_torque = raw[TORQUE_W-1:0];
      sample_q.push_back(s);
   endtask

   task automatic push_random_sample(output bit used);
      bit en, mv;
      int v;
      int kind;
      en = ($urandom_range(0, 9) != 0);
      mv = ($urandom_range(0, 9) != 0);
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3, 4: v = int'($urandom_range(0, 30000)) - 10000;
         5, 9: v = $signed(16'($urandom));
         6: v = int'($urandom_range(0, 4)) - 10002;
         7: begin
            v = int'(limit_cfg) + int'($urandom_range(0, 16)) - 8;
            if ($urandom_range(0, 1) != 0)
               v = -v;
            v = v - int'(offset_cfg);
         end
         default: begin
            case ($urandom_range(0, 2))
               0: v = 32767;
               1: v = -32768;
               default: v = 0;
            endcase
         end
      endcase
      if (v > 32767)
         v = 32767;
      else if (v < -32768)
         v = -32768;
      push_sample($urandom_range(0, CHANNELS - 1), en, mv, v);
      used = en && mv && (v >= -10000);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ALPHA:  alpha_cfg = val;
         CSR_OFFSET: offset_cfg = val[OFFSET_W-1:0];
         CSR_LIMIT:  limit_cfg = val[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(logic [ALPHA_W-1:0] a, logic signed [OFFSET_W-1:0] o,
                               logic [LIMIT_W-1:0] l);
      write_csr(CSR_ALPHA, a);
      write_csr(CSR_OFFSET, CSR_DATA_W'($unsigned(o)));
      write_csr(CSR_LIMIT, CSR_DATA_W'(l));
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (sample_q.size() != 0 || req_valid || report_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      logic nxt_valid;
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
         tx_calm = 0;
      end else begin
         nxt_valid = req_valid;
         if (req_valid && req_ready) begin
            report_q.push_back(predict_report(tx_sample));
            nxt_valid = 1'b0;
            if (tx_calm > 0) begin
               tx_calm--;
               tx_gap = 0;
            end else begin
               tx_gap = pick_pause();
               if ($urandom_range(0, 99) < 4)
                  tx_calm = $urandom_range(20, 80);
            end
         end
         if (!nxt_valid) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (sample_q.size() != 0) begin
               tx_sample = sample_q.pop_front();
               req_channel <= tx_sample.channel;
               req_motor_enabled <= tx_sample.motor_enabled;
               req_steps_active <= tx_sample.steps_active;
               req_raw_torque <= tx_sample.raw_torque;
               nxt_valid = 1'b1;
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // response monitor and ready control
   always @(posedge clock) begin
      torque_report_type exp_rpt;
      logic nxt_ready;
      int roll;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall = 0;
         rx_calm = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_hits++;
            if (report_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               exp_rpt = report_q.pop_front();
               if (rsp_over_limit !== exp_rpt.over_limit) begin
                  $error("over_limit expected %0d got %0d",
                         exp_rpt.over_limit, rsp_over_limit);
                  fail_count++;
               end
               if (rsp_reported_torque !== exp_rpt.reported_torque) begin
                  $error("reported_torque expected %0d got %0d",
                         $signed(exp_rpt.reported_torque), rsp_reported_torque);
                  fail_count++;
               end
               if (rsp_sample_used !== exp_rpt.sample_used) begin
                  $error("sample_used expected %0d got %0d",
                         exp_rpt.sample_used, rsp_sample_used);
                  fail_count++;
               end
            end
         end
         // long hold-off while requests keep coming, to back up the pipeline
         if (!hold_done && rsp_hits >= HOLD_AT && sample_q.size() > 50) begin
            hold_done = 1'b1;
            rx_stall = HOLD_CYCLES;
         end
         if (rx_stall > 0) begin
            nxt_ready = 1'b0;
            rx_stall--;
         end else begin
            nxt_ready = 1'b1;
            if (rx_calm > 0) begin
               rx_calm--;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 3)
                  rx_calm = $urandom_range(30, 120);
               else if (roll < 25)
                  rx_stall = pick_pause();
            end
         end
         rsp_ready <= nxt_ready;
      end
   end

   // watchdog: cycles without any handshake
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      bit used;
      int n_used;
      reset = 1'b1;
      req_valid = 1'b0;
      req_channel = '0;
      req_motor_enabled = 1'b0;
      req_steps_active = 1'b0;
      req_raw_torque = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_ALPHA;
      csr_wdata = '0;
      alpha_cfg = ALPHA_RESET;
      offset_cfg = OFFSET_RESET;
      limit_cfg = LIMIT_RESET;
      rsp_hits = 0;
      hold_done = 1'b0;
      fail_count = 0;
      for (int i = 0; i < CHANNELS; i++) begin
         avg_store[i] = '0;
         unseeded[i] = 1'b1;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            1: apply_config(ALPHA_ONE, 16'sd20000, 15'd0);
            2: apply_config(17'd0, -16'sd20000, 15'd20000);
            3: apply_config(17'h1ffff, 16'sh7fff, 15'h7fff);
            4: apply_config(17'd1, 16'sh8000, 15'd1);
            5: apply_config(17'($urandom_range(0, 65536)),
                            16'(int'($urandom_range(0, 40000)) - 20000),
                            15'($urandom_range(0, 20000)));
            6: apply_config(17'd65535, 16'sd0, LIMIT_RESET);
            7: begin
               write_csr(CSR_ALPHA, 17'($urandom));
               write_csr(CSR_OFFSET, 17'($urandom));
               write_csr(CSR_LIMIT, 17'($urandom));
            end
            default: ;
         endcase
         if (ph != 0) begin
            @(posedge clock);
            csr_we <= 1'b0;
         end

         if (ph == 0) begin
            // gated, error readings before and after seeding, seeds, limit edge
            push_sample(0, 0, 1, 5000);
            push_sample(0, 1, 0, 5000);
            push_sample(1, 0, 0, -32768);
            push_sample(0, 1, 1, -32768);
            push_sample(0, 1, 1, -10001);
            push_sample(0, 1, 1, -10000);
            push_sample(0, 1, 1, 32767);
            push_sample(1, 1, 1, 32767);
            push_sample(1, 1, 1, 32767);
            push_sample(2, 1, 1, 0);
            push_sample(2, 1, 1, -10001);
            push_sample(3, 1, 1, 10000);
            push_sample(3, 1, 1, 10001);
            push_sample(2, 1, 1, 20000);
         end
         if (ph == 3)
            push_sample(0, 1, 1, 32767);
         if (ph == 4)
            for (int c = 0; c < CHANNELS; c++)
               push_sample(c, 1, 1, 0);

         n_used = 0;
         while (n_used < USED_PER_PHASE) begin
            push_random_sample(used);
            if (used)
               n_used++;
         end

         // leave every channel at a large negative average for the next phase
         if (ph == 3)
            for (int c = 0; c < CHANNELS; c++)
               push_sample(c, 1, 1, -10000);

         wait_drained();
      end

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/telm_pkg.sv
hw/rtl/torque_ewma_limit_monitor.sv
test/torque_ewma_limit_monitor_tb.sv
